// ===== hw/rtl/route_table_ttl_best_quality_top_assert.svh =====
// Assertion macros for the route table.
`ifndef ROUTE_TABLE_TTL_BEST_QUALITY_TOP_ASSERT_SVH
`define ROUTE_TABLE_TTL_BEST_QUALITY_TOP_ASSERT_SVH

// Same-cycle implication under the active-low reset.
`define RTTBQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("route table assertion failed");

// Next-cycle implication under the active-low reset.
`define RTTBQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("route table assertion failed");

`endif

// ===== hw/rtl/rttbq_pkg.sv =====
package rttbq_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int TIME_BITS = 32;
    localparam int QUALITY_BITS = 16;
    localparam int STAMP_W = 32;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_REFRESHED = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_FULL      = 3'd3,
        ST_LOOKUP    = 3'd4,
        ST_REMOVED   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        mode_t                   mode;
        logic [31:0]             dest;
        logic [31:0]             hop;
        logic [47:0]             mac;
        logic [TIME_BITS-1:0]    expiry;
        logic [TIME_BITS-1:0]    now;
        logic [7:0]              port;
        logic [QUALITY_BITS-1:0] quality;
    } req_t;

    typedef struct packed {
        logic                    valid;
        logic                    hit;
        logic                    refresh;
        logic [IDX_W-1:0]        idx;
        logic [STAMP_W-1:0]      age;
        logic [QUALITY_BITS-1:0] quality;
        logic [31:0]             hop;
        logic [47:0]             mac;
        logic [7:0]              port;
        logic [TIME_BITS-1:0]    expiry;
        logic                    free_found;
        logic [IDX_W-1:0]        free_idx;
    } acc_t;

    typedef struct packed {
        logic             ins;
        logic             rfr;
        logic [IDX_W-1:0] idx;
    } wr_t;

endpackage

// ===== hw/rtl/rttbq_cell.sv =====
module rttbq_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rttbq_pkg::IDX_W-1:0]   cell_idx,
    input  rttbq_pkg::req_t               req,
    input  logic [rttbq_pkg::STAMP_W-1:0] stamp_now,
    input  rttbq_pkg::wr_t                wr,
    input  rttbq_pkg::acc_t               acc_in,
    output rttbq_pkg::acc_t               acc_out
);
    import rttbq_pkg::*;

    logic                    valid_reg, valid_next;
    logic [31:0]             dest_reg;
    logic [31:0]             hop_reg;
    logic [47:0]             mac_reg;
    logic [TIME_BITS-1:0]    exp_reg;
    logic [7:0]              port_reg;
    logic [QUALITY_BITS-1:0] qual_reg;
    logic [STAMP_W-1:0]      stamp_reg;
    acc_t                    acc_reg, acc_next;

    logic               match, same, clear_v, sel;
    logic [STAMP_W-1:0] age;

    assign match = valid_reg && (dest_reg == req.dest);
    assign same  = (hop_reg == req.hop) && (mac_reg == req.mac);
    assign age   = stamp_now - stamp_reg;
    assign sel   = (wr.idx == cell_idx);

    always_comb begin
        acc_next = acc_in;
        clear_v  = 1'b0;
        if (acc_in.valid) begin
            unique case (req.mode)
                MODE_INSERT: begin
                    if (match && (same || qual_reg >= req.quality) &&
                        (!acc_in.hit || age > acc_in.age)) begin
                        acc_next.hit     = 1'b1;
                        acc_next.refresh = same;
                        acc_next.idx     = cell_idx;
                        acc_next.age     = age;
                    end
                    if (!valid_reg && !acc_in.free_found) begin
                        acc_next.free_found = 1'b1;
                        acc_next.free_idx   = cell_idx;
                    end
                end
                MODE_LOOKUP: begin
                    if (match) begin
                        if (exp_reg > req.now) begin
                            if (!acc_in.hit || qual_reg > acc_in.quality ||
                                (qual_reg == acc_in.quality && age > acc_in.age)) begin
                                acc_next.hit     = 1'b1;
                                acc_next.idx     = cell_idx;
                                acc_next.age     = age;
                                acc_next.quality = qual_reg;
                                acc_next.hop     = hop_reg;
                                acc_next.mac     = mac_reg;
                                acc_next.port    = port_reg;
                                acc_next.expiry  = exp_reg;
                            end
                        end else begin
                            clear_v = 1'b1;
                        end
                    end
                end
                MODE_REMOVE: begin
                    if (match) begin
                        clear_v = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        priority if (wr.ins && sel) begin
            valid_next = 1'b1;
        end else if (clear_v) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.ins && sel) begin
            dest_reg  <= req.dest;
            hop_reg   <= req.hop;
            mac_reg   <= req.mac;
            exp_reg   <= req.expiry;
            port_reg  <= req.port;
            qual_reg  <= req.quality;
            stamp_reg <= stamp_now;
        end else if (wr.rfr && sel && (req.expiry > exp_reg)) begin
            exp_reg <= req.expiry;
        end
    end

    assign acc_out = acc_reg;

endmodule

// ===== hw/rtl/route_table_ttl_best_quality_top.sv =====
// Route table of TABLE_ENTRIES routes held in a row of cells. Each transaction
// other than MODE_NONE sends one scan token down the row, one cell per cycle.
// The token collects the deciding, best or free entry. A lookup clears expired
// matching entries and a remove clears matching entries as the token passes.
// A result passes from start_reg through the cell row and res_reg into the
// output registers. The input is ready again in the cycle after the result is
// registered, even while that result still waits. No new transaction is taken
// before then, and an output stall on the last result holds it off further.
module route_table_ttl_best_quality_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [31:0] s_dest_id,
    input  logic [31:0] s_hop_id,
    input  logic [47:0] s_hop_mac,
    input  logic [31:0] s_time_to_live,
    input  logic [7:0]  s_port_in,
    input  logic [15:0] s_quality_in,
    input  logic [31:0] s_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_found,
    output logic [31:0] m_hop_out,
    output logic [47:0] m_mac_out,
    output logic [7:0]  m_port_out,
    output logic [15:0] m_quality_out,
    output logic [31:0] m_expiry_out
);
    import rttbq_pkg::*;

    `include "route_table_ttl_best_quality_top_assert.svh"

    state_t             state_reg, state_next;
    req_t               req_reg;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;
    logic               start_reg;
    acc_t               res_reg;
    logic               m_valid_reg;
    status_t            status_reg, status_c;
    logic               found_reg;
    logic [31:0]        hop_reg;
    logic [47:0]        mac_reg;
    logic [7:0]         port_reg;
    logic [15:0]        qual_reg;
    logic [31:0]        exp_reg;

    logic   accept, load;
    wr_t    wr;
    acc_t   chain_head;
    acc_t   chain [TABLE_ENTRIES+1];
    logic [TIME_BITS:0] exp_sum;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign load    = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);
    assign exp_sum = {1'b0, s_now} + {1'b0, s_time_to_live};

    always_comb begin
        chain_head       = '0;
        chain_head.valid = start_reg;
    end

    assign chain[0] = chain_head;

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        rttbq_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(i)),
            .req      (req_reg),
            .stamp_now(stamp_reg),
            .wr       (wr),
            .acc_in   (chain[i]),
            .acc_out  (chain[i+1])
        );
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (mode_t'(s_mode) != MODE_NONE)) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (chain[TABLE_ENTRIES].valid) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        wr         = '0;
        status_c   = ST_LOOKUP;
        stamp_next = stamp_reg;
        unique case (req_reg.mode)
            MODE_INSERT: begin
                priority if (res_reg.hit && res_reg.refresh) begin
                    status_c = ST_REFRESHED;
                    wr.rfr   = load;
                    wr.idx   = res_reg.idx;
                end else if (res_reg.hit) begin
                    status_c = ST_REJECTED;
                end else if (res_reg.free_found) begin
                    status_c = ST_INSERTED;
                    wr.ins   = load;
                    wr.idx   = res_reg.free_idx;
                    if (load) begin
                        stamp_next = stamp_reg + 1'b1;
                    end
                end else begin
                    status_c = ST_FULL;
                end
            end
            MODE_LOOKUP: status_c = ST_LOOKUP;
            MODE_REMOVE: status_c = ST_REMOVED;
            default:     status_c = ST_LOOKUP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            stamp_reg   <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            stamp_reg <= stamp_next;
            start_reg <= accept && (mode_t'(s_mode) != MODE_NONE);
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg.mode    <= mode_t'(s_mode);
            req_reg.dest    <= s_dest_id;
            req_reg.hop     <= s_hop_id;
            req_reg.mac     <= s_hop_mac;
            req_reg.expiry  <= exp_sum[TIME_BITS] ? '1 : exp_sum[TIME_BITS-1:0];
            req_reg.now     <= s_now;
            req_reg.port    <= s_port_in;
            req_reg.quality <= s_quality_in;
        end
        if (chain[TABLE_ENTRIES].valid) begin
            res_reg <= chain[TABLE_ENTRIES];
        end
        if (load) begin
            status_reg <= status_c;
            if ((req_reg.mode == MODE_LOOKUP) && res_reg.hit) begin
                found_reg <= 1'b1;
                hop_reg   <= res_reg.hop;
                mac_reg   <= res_reg.mac;
                port_reg  <= res_reg.port;
                qual_reg  <= res_reg.quality;
                exp_reg   <= res_reg.expiry;
            end else begin
                found_reg <= 1'b0;
                hop_reg   <= '0;
                mac_reg   <= '0;
                port_reg  <= '0;
                qual_reg  <= '0;
                exp_reg   <= '0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_found       = found_reg;
    assign m_hop_out     = hop_reg;
    assign m_mac_out     = mac_reg;
    assign m_port_out    = port_reg;
    assign m_quality_out = qual_reg;
    assign m_expiry_out  = exp_reg;

    `RTTBQ_ASSERT_NOW(a_found_lookup, m_valid && m_found, m_status == ST_LOOKUP)
    `RTTBQ_ASSERT_NOW(a_token_in_scan, chain[TABLE_ENTRIES].valid, state_reg == S_SCAN)
    `RTTBQ_ASSERT_NEXT(a_accept_scan, accept && (s_mode != MODE_NONE), state_reg == S_SCAN)

endmodule

// ===== sim/route_table_ttl_best_quality_top_tb.sv =====
module route_table_ttl_best_quality_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rttbq_pkg::*;

    localparam int NSLOT = TABLE_ENTRIES;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    typedef struct {
        logic [2:0]  status;
        logic        found;
        logic [31:0] hop;
        logic [47:0] mac;
        logic [7:0]  port;
        logic [15:0] quality;
        logic [31:0] expiry;
    } route_result_t;

    typedef struct {
        mode_t       mode;
        logic [31:0] dest;
        logic [31:0] hop;
        logic [47:0] mac;
        logic [31:0] ttl;
        logic [7:0]  port;
        logic [15:0] quality;
        logic [31:0] now;
        bit          typed;
        status_t     want_status;
        bit          want_found;
    } route_request_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = '0;
    logic [31:0] s_dest_id = '0;
    logic [31:0] s_hop_id = '0;
    logic [47:0] s_hop_mac = '0;
    logic [31:0] s_time_to_live = '0;
    logic [7:0]  s_port_in = '0;
    logic [15:0] s_quality_in = '0;
    logic [31:0] s_now = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic        m_found;
    logic [31:0] m_hop_out;
    logic [47:0] m_mac_out;
    logic [7:0]  m_port_out;
    logic [15:0] m_quality_out;
    logic [31:0] m_expiry_out;

    route_table_ttl_best_quality_top uut (.*);

    always #5 aclk = ~aclk;

    bit          rt_valid [NSLOT];
    logic [31:0] rt_dest [NSLOT];
    logic [31:0] rt_hop [NSLOT];
    logic [47:0] rt_mac [NSLOT];
    logic [31:0] rt_expiry [NSLOT];
    logic [7:0]  rt_port [NSLOT];
    logic [15:0] rt_quality [NSLOT];
    logic [31:0] rt_stamp [NSLOT];
    logic [31:0] stamp_counter;

    route_result_t pending_routes[$];
    int mismatches = 0;
    int sent = 0;
    int received = 0;
    int found_hits = 0;
    int full_drops = 0;
    int refreshes = 0;
    int rejects = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit timed_out = 1'b0;

    function automatic logic [31:0] age(int i);
        return stamp_counter - rt_stamp[i];
    endfunction

    function automatic route_result_t predict_route(route_request_t r);
        route_result_t res;
        int order[NSLOT];
        int n;
        int k;
        int j;
        int free_slot;
        int best;
        logic [32:0] sum;
        logic [31:0] new_exp;
        bit decided;
        res = '{default: '0};
        n = 0;
        free_slot = -1;
        best = -1;
        decided = 1'b0;
        case (r.mode)
            MODE_INSERT: begin
                sum = {1'b0, r.now} + {1'b0, r.ttl};
                new_exp = sum[32] ? TIME_MAX : sum[31:0];
                for (int i = 0; i < NSLOT; i++) begin
                    if (!rt_valid[i]) begin
                        if (free_slot < 0) free_slot = i;
                    end else if (rt_dest[i] == r.dest) begin
                        k = n;
                        while (k > 0 && age(order[k-1]) < age(i)) begin
                            order[k] = order[k-1];
                            k--;
                        end
                        order[k] = i;
                        n++;
                    end
                end
                for (k = 0; k < n && !decided; k++) begin
                    j = order[k];
                    if (rt_hop[j] == r.hop && rt_mac[j] == r.mac) begin
                        if (new_exp > rt_expiry[j]) rt_expiry[j] = new_exp;
                        res.status = ST_REFRESHED;
                        decided = 1'b1;
                    end else if (rt_quality[j] >= r.quality) begin
                        res.status = ST_REJECTED;
                        decided = 1'b1;
                    end
                end
                if (!decided) begin
                    if (free_slot < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        rt_valid[free_slot] = 1'b1;
                        rt_dest[free_slot] = r.dest;
                        rt_hop[free_slot] = r.hop;
                        rt_mac[free_slot] = r.mac;
                        rt_expiry[free_slot] = new_exp;
                        rt_port[free_slot] = r.port;
                        rt_quality[free_slot] = r.quality;
                        rt_stamp[free_slot] = stamp_counter;
                        stamp_counter++;
                        res.status = ST_INSERTED;
                    end
                end
            end
            MODE_LOOKUP: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (rt_valid[i] && rt_dest[i] == r.dest) begin
                        if (rt_expiry[i] > r.now) begin
                            if (best < 0 || rt_quality[i] > rt_quality[best] ||
                                (rt_quality[i] == rt_quality[best] &&
                                 age(i) > age(best)))
                                best = i;
                        end else begin
                            rt_valid[i] = 1'b0;
                        end
                    end
                end
                res.status = ST_LOOKUP;
                if (best >= 0) begin
                    res.found = 1'b1;
                    res.hop = rt_hop[best];
                    res.mac = rt_mac[best];
                    res.port = rt_port[best];
                    res.quality = rt_quality[best];
                    res.expiry = rt_expiry[best];
                end
            end
            default: begin
                for (int i = 0; i < NSLOT; i++)
                    if (rt_valid[i] && rt_dest[i] == r.dest) rt_valid[i] = 1'b0;
                res.status = ST_REMOVED;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("MISMATCH t=%0t result %0d %s: got %0h expected %0h",
                 $realtime, received, field, got, want);
    endtask

    always @(posedge aclk) begin
        route_result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_routes.size() == 0) begin
                report_mismatch("unexpected transaction", m_status, 0);
            end else begin
                w = pending_routes.pop_front();
                if (m_status !== w.status) report_mismatch("status", m_status, w.status);
                if (m_found !== w.found) report_mismatch("found", m_found, w.found);
                if (m_hop_out !== w.hop) report_mismatch("hop_out", m_hop_out, w.hop);
                if (m_mac_out !== w.mac) report_mismatch("mac_out", m_mac_out, w.mac);
                if (m_port_out !== w.port) report_mismatch("port_out", m_port_out, w.port);
                if (m_quality_out !== w.quality)
                    report_mismatch("quality_out", m_quality_out, w.quality);
                if (m_expiry_out !== w.expiry)
                    report_mismatch("expiry_out", m_expiry_out, w.expiry);
                if (w.found) found_hits++;
                if (w.status == ST_FULL) full_drops++;
                if (w.status == ST_REFRESHED) refreshes++;
                if (w.status == ST_REJECTED) rejects++;
            end
            received++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn)
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction in %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_route(route_request_t r);
        route_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= r.mode;
        s_dest_id <= r.dest;
        s_hop_id <= r.hop;
        s_hop_mac <= r.mac;
        s_time_to_live <= r.ttl;
        s_port_in <= r.port;
        s_quality_in <= r.quality;
        s_now <= r.now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (r.mode != MODE_NONE) begin
            res = predict_route(r);
            if (r.typed && (res.status != r.want_status || res.found != r.want_found))
                report_mismatch("directed expectation", res.status, r.want_status);
            pending_routes.push_back(res);
        end
        sent++;
    endtask

    function automatic route_request_t mk(mode_t m, logic [31:0] d, logic [31:0] h,
                                          logic [47:0] mac, logic [31:0] ttl,
                                          logic [7:0] p, logic [15:0] q,
                                          logic [31:0] now);
        route_request_t r;
        r = '{mode: m, dest: d, hop: h, mac: mac, ttl: ttl, port: p, quality: q,
              now: now, typed: 1'b0, want_status: ST_INSERTED, want_found: 1'b0};
        return r;
    endfunction

    function automatic route_request_t mkt(route_request_t r, status_t s, bit f);
        r.typed = 1'b1;
        r.want_status = s;
        r.want_found = f;
        return r;
    endfunction

    function automatic route_request_t random_route(int dests);
        route_request_t r;
        int pick;
        pick = $urandom_range(99);
        r.mode = pick < 55 ? MODE_INSERT : pick < 85 ? MODE_LOOKUP :
                 pick < 96 ? MODE_REMOVE : MODE_NONE;
        r.dest = ($urandom_range(9) == 0) ? $urandom : 32'h8000_0000 + $urandom_range(dests);
        r.hop = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
        r.mac = ($urandom_range(3) == 0) ? {$urandom, $urandom} :
                48'hFFFF_0000_0000 | $urandom_range(1);
        r.ttl = ($urandom_range(19) == 0) ? $urandom : $urandom_range(400);
        r.port = $urandom;
        r.quality = ($urandom_range(2) == 0) ? $urandom : $urandom_range(8);
        r.now = ($urandom_range(19) == 0) ? $urandom : 32'd1000 + $urandom_range(600);
        r.typed = 1'b0;
        r.want_status = ST_INSERTED;
        r.want_found = 1'b0;
        return r;
    endfunction

    initial begin
        route_request_t directed[$];
        int phase_idle[4] = '{0, 71, 0, 33};
        int phase_stall[4] = '{0, 0, 71, 33};
        int wait_cycles;
        for (int i = 0; i < NSLOT; i++) rt_valid[i] = 1'b0;
        stamp_counter = '0;

        directed.push_back(mkt(mk(MODE_LOOKUP, 32'd7, 0, 0, 0, 0, 0, 0), ST_LOOKUP, 0));
        directed.push_back(mkt(mk(MODE_INSERT, 32'd7, 32'd1, 48'h1, 32'd100, 8'd3,
                                  16'd10, 32'd50), ST_INSERTED, 0));
        directed.push_back(mkt(mk(MODE_INSERT, 32'd7, 32'd1, 48'h1, 32'd10, 8'd3,
                                  16'd10, 32'd50), ST_REFRESHED, 0));
        directed.push_back(mkt(mk(MODE_INSERT, 32'd7, 32'd1, 48'h1, 32'd500, 8'd3,
                                  16'd10, 32'd50), ST_REFRESHED, 0));
        directed.push_back(mkt(mk(MODE_INSERT, 32'd7, 32'd2, 48'h2, 32'd100, 8'd4,
                                  16'd10, 32'd50), ST_REJECTED, 0));
        directed.push_back(mkt(mk(MODE_INSERT, 32'd7, 32'd2, 48'h2, 32'd100, 8'd4,
                                  16'd11, 32'd50), ST_INSERTED, 0));
        directed.push_back(mk(MODE_LOOKUP, 32'd7, 0, 0, 0, 0, 0, 32'd60));
        directed.push_back(mkt(mk(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF,
                                  32'hFFFF_FFFF), ST_INSERTED, 0));
        directed.push_back(mk(MODE_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 32'hFFFF_FFFE));
        directed.push_back(mk(MODE_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        directed.push_back(mkt(mk(MODE_INSERT, 32'd0, 32'd0, 48'd0, 32'd0, 8'd0, 16'd0,
                                  32'd0), ST_INSERTED, 0));
        directed.push_back(mkt(mk(MODE_LOOKUP, 32'd0, 0, 0, 0, 0, 0, 0), ST_LOOKUP, 0));
        directed.push_back(mk(MODE_NONE, 32'd7, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(MODE_LOOKUP, 32'd7, 0, 0, 0, 0, 0, 32'd149));
        for (int i = 0; i < NSLOT; i++)
            directed.push_back(mk(MODE_INSERT, 32'd900 + i, i, i, 32'd1000, i, i, 32'd10));
        directed.push_back(mkt(mk(MODE_REMOVE, 32'd7, 0, 0, 0, 0, 0, 0), ST_REMOVED, 0));
        directed.push_back(mk(MODE_LOOKUP, 32'd7, 0, 0, 0, 0, 0, 32'd60));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_route(directed[i]);
        for (int i = 0; i < NSLOT; i++)
            send_route(mk(MODE_REMOVE, 32'd900 + i, 0, 0, 0, 0, 0, 0));

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            for (int i = 0; i < 450; i++)
                send_route(random_route(ph == 3 ? 24 : 5));
        end
        s_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_routes.size() != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (40) @(posedge aclk);
        if (pending_routes.size() != 0) begin
            $display("%0d results never arrived", pending_routes.size());
            mismatches++;
        end

        $display("Sent %0d requests, checked %0d results under four idle/stall mixes.",
                 sent, received);
        $display("Lookups hit %0d, refreshed %0d, rejected %0d, table full %0d.",
                 found_hits, refreshes, rejects, full_drops);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
